// File: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define MTP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define MTP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: hdl/mtp_pkg.sv
package mtp_pkg;

  localparam int HANDLE_W   = 4;
  localparam int PERIOD_W   = 31;
  localparam int MAX_SLOTS  = 16;
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_USER_W = 2;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_CREATE = 3'd1,
    ACT_START  = 3'd2,
    ACT_STOP   = 3'd3,
    ACT_REMOVE = 3'd4,
    ACT_QUERY  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FIRED    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NO_TIMER = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_SCAN,
    S_EVAL,
    S_FLUSH
  } state_e;

  // datapath -> controller
  typedef struct packed {
    logic in_tick;      // offered item is a tick
    logic in_cmd;       // offered item is create/start/stop/remove/query
    logic out_free;     // output register can take a result this cycle
    logic slot_armed;   // scanned slot is used and running
    logic slot_latched; // scanned slot has a reference time
    logic fire;         // scanned slot has expired
    logic scan_last;    // scan index at the final slot
    logic pend_valid;   // a fire result is held back
  } mtp_stat_t;

  // controller -> datapath
  typedef struct packed {
    logic in_ready;   // input side may transfer
    logic load;       // capture offered item
    logic exec;       // run the captured command and emit its result
    logic latch;      // record now as reference time of scanned slot
    logic commit;     // scanned slot fires
    logic advance;    // step the scan index
    logic flush_emit; // emit held fire result as the final one
  } mtp_cmd_t;

endpackage

// File: hdl/mtp_ctrl.sv
module mtp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  mtp_pkg::mtp_stat_t stat_i,
  output mtp_pkg::mtp_cmd_t  cmd_o
);
  import mtp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.in_tick) begin
            state_d = S_SCAN;
          end else if (stat_i.in_cmd) begin
            state_d = S_CMD;
          end
        end
      end
      S_CMD: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!stat_i.slot_armed) begin
          cmd_o.advance = 1'b1;
          state_d       = stat_i.scan_last ? S_FLUSH : S_SCAN;
        end else if (!stat_i.slot_latched) begin
          cmd_o.latch   = 1'b1;
          cmd_o.advance = 1'b1;
          state_d       = stat_i.scan_last ? S_FLUSH : S_SCAN;
        end else begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!stat_i.fire) begin
          cmd_o.advance = 1'b1;
          state_d       = stat_i.scan_last ? S_FLUSH : S_SCAN;
        end else if (!stat_i.pend_valid || stat_i.out_free) begin
          cmd_o.commit  = 1'b1;
          cmd_o.advance = 1'b1;
          state_d       = stat_i.scan_last ? S_FLUSH : S_SCAN;
        end
      end
      S_FLUSH: begin
        if (!stat_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.flush_emit = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: hdl/mtp_datapath.sv
module mtp_datapath #(
  parameter int NSLOTS    = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mtp_pkg::mtp_cmd_t               cmd_i,
  output mtp_pkg::mtp_stat_t              stat_o,
  input  logic [mtp_pkg::IN_USER_W-1:0]   action_i,
  input  logic [mtp_pkg::HANDLE_W-1:0]    handle_i,
  input  logic [mtp_pkg::PERIOD_W-1:0]    period_i,
  input  logic                            one_shot_i,
  input  logic                            run_now_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [mtp_pkg::OUT_USER_W-1:0]  status_o,
  output logic [mtp_pkg::HANDLE_W-1:0]    slot_o,
  output logic                            active_o,
  output logic                            is_one_shot_o,
  output logic                            last_o
);
  import mtp_pkg::*;

  localparam int SLOT_W = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int CMP_W  = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;

  // captured item
  logic [IN_USER_W-1:0] act_q;
  logic [HANDLE_W-1:0]  handle_q;
  logic [PERIOD_W-1:0]  period_q;
  logic                 one_shot_q, run_now_q;

  // per-slot flags
  logic [NSLOTS-1:0] used_q, run_q, single_q, latch_q;

  logic [TIME_BITS-1:0] now_q;
  logic [SLOT_W-1:0]    idx_q;

  // timer memories
  logic [PERIOD_W-1:0]  period_mem [NSLOTS];
  logic [TIME_BITS-1:0] fire_mem   [NSLOTS];
  logic [PERIOD_W-1:0]  rd_period_q;
  logic [TIME_BITS-1:0] rd_fire_q;

  logic              pend_valid_q;
  logic [SLOT_W-1:0] pend_slot_q;

  logic                  out_valid_q;
  logic [OUT_USER_W-1:0] out_status_q;
  logic [HANDLE_W-1:0]   out_slot_q;
  logic                  out_active_q, out_single_q, out_last_q;

  logic                 load_tick;
  logic                 out_free;
  logic                 free_found;
  logic [SLOT_W-1:0]    free_idx;
  logic [SLOT_W-1:0]    h_idx;
  logic                 h_ok;
  logic [TIME_BITS-1:0] elapsed;
  logic                 fire;
  logic                 scan_last;
  logic                 period_we;
  logic                 fire_we;
  logic                 out_load;
  logic [OUT_USER_W-1:0] res_status;
  logic [HANDLE_W-1:0]   res_slot;
  logic                  res_active, res_single, res_last;

  assign load_tick = cmd_i.load && (action_i == ACT_TICK);
  assign out_free  = !out_valid_q || out_ready_i;
  assign h_idx     = handle_q[SLOT_W-1:0];
  assign h_ok      = ({1'b0, handle_q} < (HANDLE_W+1)'(NSLOTS)) && used_q[h_idx];
  assign scan_last = (idx_q == SLOT_W'(NSLOTS - 1));
  assign elapsed   = now_q - rd_fire_q;
  assign fire      = CMP_W'(elapsed) > CMP_W'(rd_period_q);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = NSLOTS - 1; k >= 0; k--) begin
      if (!used_q[k]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(k);
      end
    end
  end

  always_comb begin
    stat_o              = '0;
    stat_o.in_tick      = (action_i == ACT_TICK);
    stat_o.in_cmd       = (action_i != ACT_TICK) && (action_i <= ACT_QUERY);
    stat_o.out_free     = out_free;
    stat_o.slot_armed   = used_q[idx_q] && run_q[idx_q];
    stat_o.slot_latched = latch_q[idx_q];
    stat_o.fire         = fire;
    stat_o.scan_last    = scan_last;
    stat_o.pend_valid   = pend_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q      <= action_i;
      handle_q   <= handle_i;
      period_q   <= period_i;
      one_shot_q <= one_shot_i;
      run_now_q  <= run_now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q        <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      if (load_tick) begin
        now_q        <= now_q + 1'b1;
        idx_q        <= '0;
        pend_valid_q <= 1'b0;
      end else if (cmd_i.advance && !scan_last) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.commit) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.flush_emit) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pend_slot_q <= idx_q;
    end
  end

  // flag table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      run_q    <= '0;
      single_q <= '0;
      latch_q  <= '0;
    end else if (cmd_i.exec) begin
      case (act_q)
        ACT_CREATE: begin
          if (free_found) begin
            used_q[free_idx]   <= 1'b1;
            run_q[free_idx]    <= run_now_q;
            single_q[free_idx] <= one_shot_q;
            latch_q[free_idx]  <= 1'b0;
          end
        end
        ACT_START:  if (h_ok) run_q[h_idx] <= 1'b1;
        ACT_STOP:   if (h_ok) run_q[h_idx] <= 1'b0;
        ACT_REMOVE: begin
          if (h_ok) begin
            used_q[h_idx]   <= 1'b0;
            run_q[h_idx]    <= 1'b0;
            single_q[h_idx] <= 1'b0;
            latch_q[h_idx]  <= 1'b0;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.latch) begin
      latch_q[idx_q] <= 1'b1;
    end else if (cmd_i.commit && single_q[idx_q]) begin
      used_q[idx_q]   <= 1'b0;
      run_q[idx_q]    <= 1'b0;
      single_q[idx_q] <= 1'b0;
      latch_q[idx_q]  <= 1'b0;
    end
  end

  assign period_we = cmd_i.exec && (act_q == ACT_CREATE) && free_found;
  assign fire_we   = cmd_i.latch || cmd_i.commit;

  always_ff @(posedge clk_i) begin
    if (period_we) begin
      period_mem[free_idx] <= period_q;
    end
    rd_period_q <= period_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (fire_we) begin
      fire_mem[idx_q] <= now_q;
    end
    rd_fire_q <= fire_mem[idx_q];
  end

  // result selection
  assign out_load = cmd_i.exec || (cmd_i.commit && pend_valid_q) || cmd_i.flush_emit;

  always_comb begin
    res_status = ST_DONE;
    res_slot   = handle_q;
    res_active = 1'b0;
    res_single = 1'b0;
    res_last   = 1'b1;
    if (cmd_i.exec) begin
      if (act_q == ACT_CREATE) begin
        res_status = free_found ? ST_DONE : ST_FULL;
        res_slot   = free_found ? HANDLE_W'(free_idx) : '0;
      end else if (!h_ok) begin
        res_status = ST_NO_TIMER;
      end else if (act_q == ACT_QUERY) begin
        res_active = run_q[h_idx];
        res_single = single_q[h_idx];
      end
    end else begin
      res_status = ST_FIRED;
      res_slot   = HANDLE_W'(pend_slot_q);
      res_last   = cmd_i.flush_emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status;
      out_slot_q   <= res_slot;
      out_active_q <= res_active;
      out_single_q <= res_single;
      out_last_q   <= res_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign slot_o        = out_slot_q;
  assign active_o      = out_active_q;
  assign is_one_shot_o = out_single_q;
  assign last_o        = out_last_q;

endmodule

// File: hdl/multi_timer_pool_top.sv
// Timer pool: up to 16 timer slots (the lower of TIMERS and 16) driven by a
// stream of commands. A tick advances a TIME_BITS-wide tick counter, then
// visits each slot in order: a running slot without a reference time takes
// the current time, and a running slot whose elapsed time exceeds its period
// fires (one fired result per slot, tlast on the final one; a tick with no
// fire gives no result). Periodic slots re-arm, single-shot slots are freed.
// Create takes the lowest free slot; start, stop, remove and query address
// a slot by handle. Action codes six and seven are dropped silently.
// Create/start/stop/remove/query are accepted, then executed.
// A tick is accepted, then scanned at one slot per cycle plus one evaluate
// step per running slot already holding a reference time (the period and
// reference memory has a registered read port), then flushed; a full output
// register stretches this. The input side is ready only between items, while
// a finished result may still wait at the output.
module multi_timer_pool_top #(
  parameter int TIMERS    = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input transfer
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [3:0] handle, [34:4] period_ms, [35] one_shot, [36] run_now, [39:37] zero
  input  logic [mtp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [2:0] action
  input  logic [mtp_pkg::IN_USER_W-1:0]    s_axis_tuser,
  // result transfer
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [3:0] slot, [4] active, [5] is_one_shot, [7:6] zero
  output logic [mtp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // [1:0] status
  output logic [mtp_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  output logic                             m_axis_tlast
);
  import mtp_pkg::*;

  // handles are 4 bits wide, so slots above 16 are never reachable
  localparam int NSLOTS = (TIMERS < MAX_SLOTS) ? TIMERS : MAX_SLOTS;

  mtp_cmd_t  cmd;
  mtp_stat_t stat;

  logic [HANDLE_W-1:0] slot;
  logic                active;
  logic                is_one_shot;

  mtp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mtp_datapath #(
    .NSLOTS    (NSLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (s_axis_tuser),
    .handle_i      (s_axis_tdata[3:0]),
    .period_i      (s_axis_tdata[34:4]),
    .one_shot_i    (s_axis_tdata[35]),
    .run_now_i     (s_axis_tdata[36]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .status_o      (m_axis_tuser),
    .slot_o        (slot),
    .active_o      (active),
    .is_one_shot_o (is_one_shot),
    .last_o        (m_axis_tlast)
  );

  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = {2'b00, is_one_shot, active, slot};

endmodule

// File: hdl/mtp_checker.sv
`include "assert_macros.svh"

module mtp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [mtp_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mtp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [mtp_pkg::OUT_USER_W-1:0] m_axis_tuser,
  input logic                           m_axis_tlast
);
  import mtp_pkg::*;

  // stalled result holds
  `MTP_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast),
    "result changed while stalled")

  // only fired results may be followed by more results of the same item
  `MTP_ASSERT(a_single_last, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser != ST_FIRED) |-> m_axis_tlast,
    "command result without tlast")

  // full table reports slot zero
  `MTP_ASSERT(a_full_slot, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> (m_axis_tdata[3:0] == 4'd0),
    "full status with nonzero slot")

  // an accepted valid command closes the input until it is handled
  `MTP_ASSERT(a_busy_after_accept, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready && (s_axis_tuser <= ACT_QUERY) |=> !s_axis_tready,
    "input ready right after an accepted item")

  `MTP_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind multi_timer_pool_top mtp_checker u_mtp_checker (.*);
